// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL; clocked on clk, DMSU_ASSERT qualified by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only outside reset
`define DMSU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dmsu assertion failed");

// property checked at every edge, reset included
`define DMSU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dmsu assertion failed");

`endif

// ===== rtl/core/dmsu_pkg.sv =====
// ----------------------------------------------------------------------------
// dmsu_pkg
// Types and constants of the decimal mantissa scale unit.
// ----------------------------------------------------------------------------
package dmsu_pkg;

  localparam int FIELD_BITS = 96;  // mantissa bits carried on the ports
  localparam int STEP_BITS  = 8;   // quotient bits resolved per divide stage

  typedef enum logic [1:0] {
    MODE_DIV = 2'd0,
    MODE_MUL = 2'd1,
    MODE_ADD = 2'd2
  } mode_t;

  localparam logic [4:0] TEN      = 5'd10;
  localparam logic [4:0] REM_MAX  = 5'd9;

  // side band that follows the mantissa down the pipeline
  typedef struct packed {
    mode_t      mode;
    logic [7:0] scale;
    logic       sign;
    logic       ovf;
    logic [3:0] rem;
  } side_t;

endpackage

// ===== rtl/core/decimal_mantissa_scale_unit.sv =====
// ----------------------------------------------------------------------------
// decimal_mantissa_scale_unit
// Divide by ten, multiply by ten, add or pass through a decimal mantissa with its scale.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one operand set per transfer, operation code on
//   in_tuser (0 divide by ten, 1 multiply by ten, 2 add, 3 pass through).
//   Output stream (out_*): exactly one result per input transfer, in order.
//   The entry stage does the wide x10 and add; the divide by ten then
//   resolves 8 quotient bits in each following stage, fewer in the last
//   when MANTISSA_BITS is not a multiple of 8.
//   Throughput: one transfer per cycle when out_tready stays high.
//   Stall: out_tready low holds full stages, empty ones fill; in_tready drops
//   only once every stage holds an item. Nothing is lost or repeated.
//   Reset: synchronous, active low; clears all stage valid bits, so out_tvalid
//   is low and in_tready high in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module decimal_mantissa_scale_unit #(
  parameter int MANTISSA_BITS = 96
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_low[63:0], a_high[95:64], b_low[159:96], b_high[191:160],
  // scale[199:192], sign_in[200], zero pad[207:201]
  input  logic [207:0] in_tdata,
  // mode[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // res_low[63:0], res_high[95:64], res_scale[103:96], res_sign[104],
  // remainder[108:105], overflow[109], zero pad[111:110]
  output logic [111:0] out_tdata
);

  localparam int M   = MANTISSA_BITS;
  localparam int FB  = dmsu_pkg::FIELD_BITS;
  localparam int SB  = dmsu_pkg::STEP_BITS;
  localparam int NS  = (M + SB - 1) / SB;
  localparam int EXT = (M > FB) ? M : FB;

  logic [EXT-1:0]    a_ext;
  logic [EXT-1:0]    b_ext;
  logic [EXT-1:0]    res_ext;
  logic [M-1:0]      a_m;
  logic [M-1:0]      b_m;

  logic              vld  [NS+1];
  logic              rdy  [NS+1];
  logic [M-1:0]      work [NS+1];
  dmsu_pkg::side_t   side [NS+1];

  assign a_ext = EXT'(in_tdata[95:0]);
  assign b_ext = EXT'(in_tdata[191:96]);
  assign a_m   = a_ext[M-1:0];
  assign b_m   = b_ext[M-1:0];

  dmsu_prep #(
    .MANTISSA_BITS (M)
  ) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (dmsu_pkg::mode_t'(in_tuser)),
    .in_a      (a_m),
    .in_b      (b_m),
    .in_scale  (in_tdata[199:192]),
    .in_sign   (in_tdata[200]),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_work  (work[0]),
    .out_side  (side[0])
  );

  for (genvar i = 0; i < NS; i++) begin : g_div
    localparam int STEPS = (i < NS - 1) ? SB : (M - SB * (NS - 1));
    dmsu_div_stage #(
      .MANTISSA_BITS (M),
      .STEPS         (STEPS)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_work   (work[i]),
      .in_side   (side[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_work  (work[i+1]),
      .out_side  (side[i+1])
    );
  end

  assign rdy[NS]    = out_tready;
  assign out_tvalid = vld[NS];
  assign res_ext    = EXT'(work[NS]);

  assign out_tdata = {2'b00,
                      side[NS].ovf,
                      side[NS].rem,
                      side[NS].sign,
                      side[NS].scale,
                      res_ext[FB-1:0]};

  `DMSU_ASSERT(a_rem_range, out_tvalid |-> (side[NS].rem <= 4'd9))
  `DMSU_ASSERT(a_rem_div_only, out_tvalid && (side[NS].mode != dmsu_pkg::MODE_DIV) |-> (side[NS].rem == 4'd0))
  `DMSU_ASSERT(a_div_no_ovf, out_tvalid && (side[NS].mode == dmsu_pkg::MODE_DIV) |-> !side[NS].ovf)
  `DMSU_ASSERT(a_stall_full, !in_tready |-> (vld[0] && out_tvalid && !out_tready))

endmodule

// ===== rtl/core/dmsu_prep.sv =====
// ----------------------------------------------------------------------------
// dmsu_prep
// Entry stage: does the x10 and add paths, sets scale and the overflow flag.
// ----------------------------------------------------------------------------
module dmsu_prep #(
  parameter int MANTISSA_BITS = 96
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  dmsu_pkg::mode_t            in_mode,
  input  logic [MANTISSA_BITS-1:0]   in_a,
  input  logic [MANTISSA_BITS-1:0]   in_b,
  input  logic [7:0]                 in_scale,
  input  logic                       in_sign,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [MANTISSA_BITS-1:0]   out_work,
  output dmsu_pkg::side_t            out_side
);

  localparam int M = MANTISSA_BITS;

  logic                 en;
  logic                 valid_r;
  logic [M-1:0]         work_r;
  logic [M-1:0]         work_nxt;
  dmsu_pkg::side_t      side_r;
  dmsu_pkg::side_t      side_nxt;
  logic [M-1:0]         x2;
  logic [M-1:0]         x8;
  logic [M:0]           mul_sum;
  logic [M:0]           add_sum;
  logic                 top3;

  assign x2      = {in_a[M-2:0], 1'b0};
  assign x8      = {in_a[M-4:0], 3'b000};
  assign mul_sum = {1'b0, x8} + {1'b0, x2};
  assign add_sum = {1'b0, in_a} + {1'b0, in_b};
  assign top3    = |in_a[M-1:M-3];

  always_comb begin
    work_nxt       = in_a;
    side_nxt.mode  = in_mode;
    side_nxt.scale = in_scale;
    side_nxt.sign  = in_sign;
    side_nxt.ovf   = 1'b0;
    side_nxt.rem   = 4'd0;
    case (in_mode)
      dmsu_pkg::MODE_DIV: begin
        side_nxt.scale = in_scale - 8'd1;
      end
      dmsu_pkg::MODE_MUL: begin
        if (top3 || mul_sum[M]) begin
          side_nxt.ovf = 1'b1;
        end else begin
          work_nxt       = mul_sum[M-1:0];
          side_nxt.scale = in_scale + 8'd1;
        end
      end
      dmsu_pkg::MODE_ADD: begin
        work_nxt     = add_sum[M-1:0];
        side_nxt.ovf = add_sum[M];
      end
      default: begin
        work_nxt = in_a;
      end
    endcase
  end

  assign en       = !valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work_r <= work_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_work  = work_r;
  assign out_side  = side_r;

endmodule

// ===== rtl/core/dmsu_div_stage.sv =====
// ----------------------------------------------------------------------------
// dmsu_div_stage
// One restoring divide-by-ten stage: shifts STEPS quotient bits into the word in divide mode; other modes pass through.
// ----------------------------------------------------------------------------
module dmsu_div_stage #(
  parameter int MANTISSA_BITS = 96,
  parameter int STEPS         = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [MANTISSA_BITS-1:0]   in_work,
  input  dmsu_pkg::side_t            in_side,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [MANTISSA_BITS-1:0]   out_work,
  output dmsu_pkg::side_t            out_side
);

  localparam int M = MANTISSA_BITS;

  logic             en;
  logic             valid_r;
  logic [M-1:0]     work_r;
  logic [M-1:0]     work_nxt;
  dmsu_pkg::side_t  side_r;
  dmsu_pkg::side_t  side_nxt;
  logic [4:0]       trial;
  logic [3:0]       rem;

  always_comb begin
    work_nxt = in_work;
    side_nxt = in_side;
    rem      = in_side.rem;
    trial    = 5'd0;
    if (in_side.mode == dmsu_pkg::MODE_DIV) begin
      for (int k = 0; k < STEPS; k++) begin
        trial    = {rem, work_nxt[M-1]};
        work_nxt = {work_nxt[M-2:0], 1'b0};
        if (trial > dmsu_pkg::REM_MAX) begin
          work_nxt[0] = 1'b1;
          rem         = 4'(trial - dmsu_pkg::TEN);
        end else begin
          rem = trial[3:0];
        end
      end
      side_nxt.rem = rem;
    end
  end

  assign en       = !valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work_r <= work_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_work  = work_r;
  assign out_side  = side_r;

endmodule
